@@ design/wph_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wph_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Format codes
  localparam logic [2:0] FMT_NONE     = 3'd0;
  localparam logic [2:0] FMT_MONO8    = 3'd1;
  localparam logic [2:0] FMT_MONO16   = 3'd2;
  localparam logic [2:0] FMT_STEREO8  = 3'd3;
  localparam logic [2:0] FMT_STEREO16 = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_TOO_SMALL = 3'd0;
  localparam logic [2:0] ERR_NO_RIFF   = 3'd1;
  localparam logic [2:0] ERR_NO_WAVE   = 3'd2;
  localparam logic [2:0] ERR_OVERRUN   = 3'd3;
  localparam logic [2:0] ERR_FMT_SIZE  = 3'd4;
  localparam logic [2:0] ERR_NOT_PCM   = 3'd5;
  localparam logic [2:0] ERR_BITS      = 3'd6;
  localparam logic [2:0] ERR_CHANNELS  = 3'd7;

  // Tags, big-endian in the order the bytes arrive
  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  // File layout
  localparam logic [31:0] RIFF_END      = 32'd3;
  localparam logic [31:0] SIZE_END      = 32'd7;
  localparam logic [31:0] WAVE_END      = 32'd11;
  localparam logic [31:0] HDR_MIN       = 32'd12;
  localparam logic [32:0] CHUNK_HDR_LEN = 33'd8;
  localparam logic [31:0] FMT_LEN       = 32'd16;

  // Result buffer
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [2:0]  fmt;
    logic [2:0]  err;
    logic [31:0] data_size;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [15:0] channels;
    logic        last;
  } wph_result_t;

  // Results of one byte, in order; count is 0, 1 or 2
  typedef struct packed {
    logic [1:0]  count;
    wph_result_t r0;
    wph_result_t r1;
  } wph_push_t;

  // Pick one byte of a four-character tag
  function automatic logic [7:0] tag_char(input logic [31:0] tag, input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = tag[31:24];
      2'd1:    c = tag[23:16];
      2'd2:    c = tag[15:8];
      default: c = tag[7:0];
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/wph_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wph_core import wph_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        advance_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic [31:0] len_i,
  output wph_push_t        push_o
);

  localparam logic [2:0] PH_RIFF   = 3'd0;
  localparam logic [2:0] PH_SIZE   = 3'd1;
  localparam logic [2:0] PH_WAVE   = 3'd2;
  localparam logic [2:0] PH_HEADER = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;
  localparam logic [2:0] PH_TAIL   = 3'd5;
  localparam logic [2:0] PH_HALT   = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] clen_q, clen_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [2:0]  fmt_q, fmt_d;
  logic [31:0] ds_q, ds_d;

  logic        live;
  logic        final_byte;
  logic        err_hit;
  logic [2:0]  err_code;
  logic        pay_hit;
  logic        sum_hit;
  logic [3:0]  rem_eff;
  logic [3:0]  rem_left;
  logic [31:0] tag_w;
  logic [31:0] clen_w;
  logic [31:0] off;
  logic [15:0] bits_w;
  wph_result_t c_res;
  wph_result_t s_res;

  assign live       = advance_i && (pos_q < len_i);
  assign final_byte = ({1'b0, pos_q} + 33'd1) == {1'b0, len_i};
  assign off        = clen_q - rem_q;

  // Parse one byte and work out the next state
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    tag_d    = tag_q;
    clen_d   = clen_q;
    rem_d    = rem_q;
    ch_d     = ch_q;
    rate_d   = rate_q;
    bits_d   = bits_q;
    fmt_d    = fmt_q;
    ds_d     = ds_q;
    err_hit  = 1'b0;
    err_code = ERR_TOO_SMALL;
    pay_hit  = 1'b0;
    rem_eff  = 4'd0;
    rem_left = 4'd0;
    tag_w    = tag_q;
    clen_w   = clen_q;
    bits_w   = bits_q;
    if (live) begin
      pos_d = pos_q + 32'd1;
      case (phase_q)
        PH_RIFF: begin
          if (pos_q == '0 && len_i < HDR_MIN) begin
            err_hit  = 1'b1;
            err_code = ERR_TOO_SMALL;
          end else if (byte_i != tag_char(TAG_RIFF, pos_q[1:0])) begin
            err_hit  = 1'b1;
            err_code = ERR_NO_RIFF;
          end else if (pos_q >= RIFF_END) begin
            phase_d = PH_SIZE;
          end
        end
        PH_SIZE: begin
          if (pos_q >= SIZE_END) begin
            phase_d = PH_WAVE;
          end
        end
        PH_WAVE: begin
          if (byte_i != tag_char(TAG_WAVE, pos_q[1:0])) begin
            err_hit  = 1'b1;
            err_code = ERR_NO_WAVE;
          end else if (pos_q >= WAVE_END) begin
            phase_d = PH_HEADER;
            rem_d   = '0;
          end
        end
        PH_HEADER: begin
          if (rem_q == '0 && ({1'b0, pos_q} + CHUNK_HDR_LEN) > {1'b0, len_i}) begin
            // Tail too short for a header: ignore the rest
            phase_d = PH_TAIL;
          end else begin
            if (rem_q == '0) begin
              rem_eff = 4'd8;
              tag_w   = '0;
              clen_w  = '0;
            end else begin
              rem_eff = rem_q[3:0];
            end
            // First four bytes are the tag, the next four the length
            if (rem_eff > 4'd4) begin
              tag_w = {tag_w[23:0], byte_i};
            end else begin
              case (rem_eff)
                4'd4:    clen_w[7:0]   = byte_i;
                4'd3:    clen_w[15:8]  = byte_i;
                4'd2:    clen_w[23:16] = byte_i;
                default: clen_w[31:24] = byte_i;
              endcase
            end
            rem_left = rem_eff - 4'd1;
            tag_d    = tag_w;
            clen_d   = clen_w;
            rem_d    = {28'd0, rem_left};
            if (rem_left == 4'd0) begin
              if (({2'b0, pos_q} + 34'd1 + {2'b0, clen_w}) > {2'b0, len_i}) begin
                err_hit  = 1'b1;
                err_code = ERR_OVERRUN;
              end else if (tag_w == TAG_FMT && clen_w != FMT_LEN) begin
                err_hit  = 1'b1;
                err_code = ERR_FMT_SIZE;
              end else begin
                if (tag_w == TAG_DATA) begin
                  ds_d = clen_w;
                end
                if (clen_w != '0) begin
                  phase_d = PH_BODY;
                  rem_d   = clen_w;
                end
              end
            end
          end
        end
        PH_BODY: begin
          rem_d = rem_q - 32'd1;
          if (rem_q == 32'd1) begin
            phase_d = PH_HEADER;
          end
          if (tag_q == TAG_DATA) begin
            pay_hit = 1'b1;
          end else if (tag_q == TAG_FMT) begin
            // fmt body is exactly sixteen bytes, so the low offset bits suffice
            case (off[3:0])
              4'd0: bits_d = {8'd0, byte_i};
              4'd1: begin
                bits_w = {byte_i, bits_q[7:0]};
                bits_d = bits_w;
                if (bits_w != 16'd1) begin
                  err_hit  = 1'b1;
                  err_code = ERR_NOT_PCM;
                end
              end
              4'd2: ch_d = {8'd0, byte_i};
              4'd3: ch_d = {byte_i, ch_q[7:0]};
              4'd4: rate_d = {24'd0, byte_i};
              4'd5: rate_d = {16'd0, byte_i, rate_q[7:0]};
              4'd6: rate_d = {8'd0, byte_i, rate_q[15:0]};
              4'd7: rate_d = {byte_i, rate_q[23:0]};
              4'd14: bits_d = {8'd0, byte_i};
              4'd15: begin
                bits_w = {byte_i, bits_q[7:0]};
                bits_d = bits_w;
                if (ch_q != 16'd1 && ch_q != 16'd2) begin
                  err_hit  = 1'b1;
                  err_code = ERR_CHANNELS;
                end else if (bits_w != 16'd8 && bits_w != 16'd16) begin
                  err_hit  = 1'b1;
                  err_code = ERR_BITS;
                end else if (ch_q == 16'd1) begin
                  fmt_d = (bits_w == 16'd16) ? FMT_MONO16 : FMT_MONO8;
                end else begin
                  fmt_d = (bits_w == 16'd16) ? FMT_STEREO16 : FMT_STEREO8;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
      // The first error halts the parse for the rest of the file
      if (err_hit) begin
        phase_d = PH_HALT;
      end
    end
  end

  assign sum_hit = live && final_byte && (phase_d != PH_HALT);

  // Assemble the result records
  always_comb begin
    c_res          = '0;
    c_res.kind     = err_hit ? KIND_ERROR : KIND_PAYLOAD;
    c_res.payload  = err_hit ? 8'd0 : byte_i;
    c_res.fmt      = err_hit ? FMT_NONE : fmt_q;
    c_res.err      = err_hit ? err_code : 3'd0;
    c_res.last     = !sum_hit;
    s_res           = '0;
    s_res.kind      = KIND_SUMMARY;
    s_res.fmt       = fmt_d;
    s_res.data_size = ds_d;
    s_res.rate      = rate_d;
    s_res.bits      = bits_d;
    s_res.channels  = ch_d;
    s_res.last      = 1'b1;
  end

  always_comb begin
    push_o = '0;
    if (err_hit || pay_hit) begin
      push_o.r0    = c_res;
      push_o.r1    = s_res;
      push_o.count = sum_hit ? 2'd2 : 2'd1;
    end else if (sum_hit) begin
      push_o.r0    = s_res;
      push_o.count = 2'd1;
    end
  end

  // Hold parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      pos_q   <= '0;
      tag_q   <= '0;
      clen_q  <= '0;
      rem_q   <= '0;
      ch_q    <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      fmt_q   <= FMT_NONE;
      ds_q    <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      tag_q   <= tag_d;
      clen_q  <= clen_d;
      rem_q   <= rem_d;
      ch_q    <= ch_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      fmt_q   <= fmt_d;
      ds_q    <= ds_d;
    end
  end

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count != 2'd0) |-> advance_i)
    else $error("result produced without a byte in flight");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HALT) |=> (phase_q == PH_HALT))
    else $error("parser left the halted phase");

  a_pair_ends_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (push_o.r0.kind == KIND_PAYLOAD &&
                                push_o.r1.kind == KIND_SUMMARY))
    else $error("two results from one byte must be payload then summary");

endmodule

`default_nettype wire

@@ design/wph_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wph_fifo import wph_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire wph_push_t push_i,
  output logic           room_o,
  output wph_result_t    head_o,
  output logic           valid_o,
  input  wire logic      ready_i
);

  wph_result_t        mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   count_q, count_d;
  logic               pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign head_o  = mem_q[rd_ptr_q];
  // Room for the two results one byte can cause
  assign room_o  = count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);

  assign wr_ptr_d = wr_ptr_q + FIFO_AW'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + FIFO_AW'(pop);
  assign count_d  = count_q + (FIFO_AW + 1)'(push_i.count) - (FIFO_AW + 1)'(pop);

  // Store pushed results in order
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + FIFO_AW'(1)] <= push_i.r1;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, count_q} + (FIFO_AW + 2)'(push_i.count)) <= (FIFO_AW + 2)'(FIFO_DEPTH))
    else $error("result buffer overflow");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (FIFO_AW'(wr_ptr_q - rd_ptr_q) == count_q[FIFO_AW-1:0]))
    else $error("result buffer pointers disagree with fill level");

endmodule

`default_nettype wire

@@ design/wav_pcm_header_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Path: a taken byte is held in the input register, then parsed when the result buffer
//   has room; its results are queued there until the master side takes them.
// Throughput: one byte per cycle while the result buffer has room; a data byte
//   ending the file yields two results, drained one per cycle while tready is high.
// Reset: asynchronous, active low; clears parse state, held fields, buffer and
//   file_length (0), so the parser restarts at the RIFF tag.
module wav_pcm_header_parser import wph_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // file_length register
  input  wire logic         cfg_we_i,
  input  wire logic [31:0]  cfg_wdata_i,
  // byte input
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] byte_value
  // result output
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [7:0] payload_byte, [10:8] format_code, [13:11] error_code,
  // [45:14] data_size, [77:46] sample_rate, [93:78] bits_per_sample,
  // [109:94] channel_count, [111:110] zero
  output logic [111:0]      m_axis_tdata,
  output logic [1:0]        m_axis_tuser,   // [1:0] result_kind
  output logic              m_axis_tlast    // last_of_run
);

  logic [31:0]  len_q;
  logic [7:0]   byte_q;
  logic         in_valid_q, in_valid_d;
  logic         room;
  logic         advance;
  logic         accept;
  wph_push_t    push;
  wph_result_t  head;

  assign advance       = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || room;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  // Hold file length and the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      in_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= s_axis_tdata;
    end
  end

  wph_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (byte_q),
    .len_i     (len_q),
    .push_o    (push)
  );

  wph_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready)
  );

  // Pack the head result onto the master side
  assign m_axis_tdata = {2'b00, head.channels, head.bits, head.rate, head.data_size,
                         head.err, head.fmt, head.payload};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import wph_pkg::*;

  // Parser progress through the file
  typedef enum logic [2:0] {
    AT_RIFF, AT_SIZE, AT_WAVE, AT_HEADER, AT_BODY, AT_TAIL, HALTED
  } wav_phase_e;

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          cfg_we_i      = 1'b0;
  logic [31:0]   cfg_wdata_i   = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [7:0]    s_axis_tdata  = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [111:0]  m_axis_tdata;
  logic [1:0]    m_axis_tuser;
  logic          m_axis_tlast;

  wav_pcm_header_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Expected parser state, mirrored byte by byte
  logic [31:0] file_len      = '0;
  logic [31:0] pos_in_file   = '0;
  wav_phase_e  wav_phase     = AT_RIFF;
  logic [31:0] hdr_tag       = '0;
  logic [31:0] hdr_len       = '0;
  logic [31:0] left_in_chunk = '0;
  logic [15:0] fmt_channels  = '0;
  logic [31:0] fmt_rate      = '0;
  logic [15:0] fmt_bits      = '0;
  logic [2:0]  fmt_code      = FMT_NONE;
  logic [31:0] data_len      = '0;

  // Stimulus and expected results
  logic [7:0]  pending_bytes[$];
  logic [7:0]  staged_bytes[$];
  wph_result_t pending_results[$];
  wph_result_t want;

  bit    calm        = 1'b0;
  bit    byte_taken  = 1'b0;
  int    in_gap      = 0;
  int    out_stall   = 0;
  int    mismatches  = 0;
  int    bytes_taken = 0;
  int    results_seen = 0;
  int    n_payload   = 0;
  int    n_summary   = 0;
  int    n_error     = 0;
  int    n_writes    = 0;
  string ending_name = "none";

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 25) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val, input int idx);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                                idx, name, got, exp_val));
  endtask

  // Work out the results of one file byte and queue them
  task automatic parse_wav_byte(input logic [7:0] b);
    wph_result_t     res[2];
    wph_result_t     r;
    int              n;
    int              i;
    logic            is_final;
    logic            failed;
    logic [2:0]      code;
    logic [31:0]     off;
    logic [31:0]     tag_sh;
    longint unsigned lpos;
    longint unsigned llen;
    n      = 0;
    failed = 1'b0;
    code   = ERR_TOO_SMALL;
    lpos   = 64'(pos_in_file);
    llen   = 64'(file_len);
    if (lpos < llen) begin
      is_final = (lpos + 1 == llen);
      case (wav_phase)
        AT_RIFF: begin
          tag_sh = TAG_RIFF >> (8 * (3 - pos_in_file[1:0]));
          if (pos_in_file == 0 && file_len < 32'd12) begin
            failed = 1'b1;
            code   = ERR_TOO_SMALL;
          end else if (b != tag_sh[7:0]) begin
            failed = 1'b1;
            code   = ERR_NO_RIFF;
          end else if (pos_in_file >= 32'd3) begin
            wav_phase = AT_SIZE;
          end
        end
        AT_SIZE: begin
          if (pos_in_file >= 32'd7) wav_phase = AT_WAVE;
        end
        AT_WAVE: begin
          tag_sh = TAG_WAVE >> (8 * (3 - pos_in_file[1:0]));
          if (b != tag_sh[7:0]) begin
            failed = 1'b1;
            code   = ERR_NO_WAVE;
          end else if (pos_in_file >= 32'd11) begin
            wav_phase     = AT_HEADER;
            left_in_chunk = '0;
          end
        end
        AT_HEADER: begin
          // too little left for a chunk header: ignore the rest of the file
          if (left_in_chunk == 0 && lpos + 8 > llen) begin
            wav_phase = AT_TAIL;
          end else begin
            if (left_in_chunk == 0) begin
              left_in_chunk = 32'd8;
              hdr_tag       = '0;
              hdr_len       = '0;
            end
            if (left_in_chunk > 32'd4) hdr_tag = {hdr_tag[23:0], b};
            else hdr_len = hdr_len | ({24'd0, b} << (8 * (4 - left_in_chunk)));
            left_in_chunk = left_in_chunk - 1;
            if (left_in_chunk == 0) begin
              if (lpos + 1 + hdr_len > llen) begin
                failed = 1'b1;
                code   = ERR_OVERRUN;
              end else if (hdr_tag == TAG_FMT && hdr_len != 32'd16) begin
                failed = 1'b1;
                code   = ERR_FMT_SIZE;
              end else begin
                if (hdr_tag == TAG_DATA) data_len = hdr_len;
                if (hdr_len != 0) begin
                  wav_phase     = AT_BODY;
                  left_in_chunk = hdr_len;
                end
              end
            end
          end
        end
        AT_BODY: begin
          off = hdr_len - left_in_chunk;
          if (hdr_tag == TAG_DATA) begin
            r         = '0;
            r.kind    = KIND_PAYLOAD;
            r.payload = b;
            r.fmt     = fmt_code;
            res[n]    = r;
            n++;
          end else if (hdr_tag == TAG_FMT) begin
            case (off)
              32'd0: fmt_bits = {8'd0, b};
              32'd1: begin
                fmt_bits[15:8] = b;
                if (fmt_bits != 16'd1) begin
                  failed = 1'b1;
                  code   = ERR_NOT_PCM;
                end
              end
              32'd2: fmt_channels = {8'd0, b};
              32'd3: fmt_channels[15:8] = b;
              32'd4: fmt_rate = {24'd0, b};
              32'd5: fmt_rate[15:8] = b;
              32'd6: fmt_rate[23:16] = b;
              32'd7: fmt_rate[31:24] = b;
              32'd14: fmt_bits = {8'd0, b};
              32'd15: begin
                fmt_bits[15:8] = b;
                // channel count is checked ahead of bit depth
                if (fmt_channels != 16'd1 && fmt_channels != 16'd2) begin
                  failed = 1'b1;
                  code   = ERR_CHANNELS;
                end else if (fmt_bits != 16'd8 && fmt_bits != 16'd16) begin
                  failed = 1'b1;
                  code   = ERR_BITS;
                end else if (fmt_channels == 16'd1) begin
                  fmt_code = (fmt_bits == 16'd16) ? FMT_MONO16 : FMT_MONO8;
                end else begin
                  fmt_code = (fmt_bits == 16'd16) ? FMT_STEREO16 : FMT_STEREO8;
                end
              end
              default: ;
            endcase
          end
          if (!failed) begin
            left_in_chunk = left_in_chunk - 1;
            if (left_in_chunk == 0) wav_phase = AT_HEADER;
          end
        end
        default: ;
      endcase
      if (failed) begin
        wav_phase = HALTED;
        r         = '0;
        r.kind    = KIND_ERROR;
        r.err     = code;
        res[0]    = r;
        n         = 1;
      end
      if (is_final && wav_phase != HALTED) begin
        r           = '0;
        r.kind      = KIND_SUMMARY;
        r.fmt       = fmt_code;
        r.data_size = data_len;
        r.rate      = fmt_rate;
        r.bits      = fmt_bits;
        r.channels  = fmt_channels;
        res[n]      = r;
        n++;
      end
      pos_in_file = pos_in_file + 1;
      for (i = 0; i < n; i++) begin
        r      = res[i];
        r.last = (i == n - 1);
        pending_results.push_back(r);
      end
    end
  endtask

  // Mostly short gaps, a few long ones, none in a calm phase
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [31:0] pick_rate();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Tag of a chunk to be skipped, often one bit away from a known tag
  function automatic logic [31:0] other_tag();
    logic [31:0] t;
    if ($urandom_range(0, 1) == 1)
      t = ($urandom_range(0, 1) == 1 ? TAG_FMT : TAG_DATA) ^ (32'd1 << $urandom_range(0, 31));
    else
      t = $urandom;
    if (t == TAG_FMT || t == TAG_DATA) t = t ^ 32'd1;
    return t;
  endfunction

  task automatic stage_le(input logic [31:0] value, input int nbytes);
    int i;
    for (i = 0; i < nbytes; i++) staged_bytes.push_back(value[8*i +: 8]);
  endtask

  task automatic stage_tag(input logic [31:0] tag);
    staged_bytes.push_back(tag[31:24]);
    staged_bytes.push_back(tag[23:16]);
    staged_bytes.push_back(tag[15:8]);
    staged_bytes.push_back(tag[7:0]);
  endtask

  task automatic stage_chunk(input logic [31:0] tag, input int len);
    int i;
    stage_tag(tag);
    stage_le(len, 4);
    for (i = 0; i < len; i++) staged_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic stage_fmt(input logic [15:0] audio, input logic [15:0] channels,
                           input logic [31:0] rate, input logic [15:0] bits);
    stage_tag(TAG_FMT);
    stage_le(32'd16, 4);
    stage_le(32'(audio), 2);
    stage_le(32'(channels), 2);
    stage_le(rate, 4);
    stage_le($urandom, 4);
    stage_le($urandom, 2);
    stage_le(32'(bits), 2);
  endtask

  task automatic write_length(input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    file_len = value;
    n_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hand the staged bytes to the driver, growing the file to cover them if asked
  task automatic send_staged(input bit grow);
    if (grow) write_length(file_len + 32'(staged_bytes.size()));
    while (staged_bytes.size() != 0) pending_bytes.push_back(staged_bytes.pop_front());
  endtask

  // Wait for every transfer and result, then let the pipeline settle
  task automatic wait_idle();
    int waited;
    waited = 0;
    while (pending_bytes.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (pending_results.size() != 0 && waited < 4000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
      pending_results.delete();
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Byte driver: hold a byte until its transfer, then idle for a while
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || byte_taken) begin
      if (in_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap--;
      end else if (pending_bytes.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_bytes.pop_front();
        in_gap = pick_idle();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      m_axis_tready <= 1'b0;
      out_stall--;
    end else begin
      m_axis_tready <= 1'b1;
      out_stall = pick_idle();
    end
  end

  // Predict on each byte transfer, check each result transfer
  always @(posedge clk_i) begin
    byte_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (byte_taken) begin
      bytes_taken++;
      parse_wav_byte(s_axis_tdata);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      case (m_axis_tuser)
        KIND_PAYLOAD: n_payload++;
        KIND_SUMMARY: n_summary++;
        default:      n_error++;
      endcase
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d of kind %0d with nothing expected",
                                  results_seen, m_axis_tuser));
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(m_axis_tuser), 32'(want.kind), results_seen);
        check_field("payload", 32'(m_axis_tdata[7:0]), 32'(want.payload), results_seen);
        check_field("format", 32'(m_axis_tdata[10:8]), 32'(want.fmt), results_seen);
        check_field("error", 32'(m_axis_tdata[13:11]), 32'(want.err), results_seen);
        check_field("data_size", m_axis_tdata[45:14], want.data_size, results_seen);
        check_field("rate", m_axis_tdata[77:46], want.rate, results_seen);
        check_field("bits", 32'(m_axis_tdata[93:78]), 32'(want.bits), results_seen);
        check_field("channels", 32'(m_axis_tdata[109:94]), 32'(want.channels),
                    results_seen);
        check_field("last", 32'(m_axis_tlast), 32'(want.last), results_seen);
      end
    end
  end

  initial begin
    int          nchunks;
    int          pick;
    int          len;
    int          ending;
    int          k;
    logic [15:0] bad;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // Empty file: every byte lies past the end
    write_length(32'd0);
    stage_le($urandom, 3);
    send_staged(1'b0);
    wait_idle();

    // Header, data ahead of any fmt, then an empty chunk ending the file
    stage_tag(TAG_RIFF);
    stage_le(32'hFF00AA55, 4);
    stage_tag(TAG_WAVE);
    stage_tag(TAG_DATA);
    stage_le(32'd2, 4);
    staged_bytes.push_back(8'h00);
    staged_bytes.push_back(8'hFF);
    stage_tag(other_tag());
    stage_le(32'd0, 4);
    send_staged(1'b1);
    wait_idle();

    // Stereo 16-bit at the top rate; the file ends on a data byte
    stage_fmt(16'd1, 16'd2, 32'hFFFF_FFFF, 16'd16);
    stage_chunk(TAG_DATA, 1);
    send_staged(1'b1);
    wait_idle();

    // Grow the file a few well-formed chunks at a time
    while (file_len < 32'd530) begin
      calm    = ($urandom_range(0, 3) == 0);
      nchunks = $urandom_range(1, 4);
      for (k = 0; k < nchunks; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
          stage_chunk(TAG_DATA, len);
        end else if (pick < 70) begin
          stage_fmt(16'd1, 16'($urandom_range(1, 2)), pick_rate(),
                    ($urandom_range(0, 1) == 1) ? 16'd16 : 16'd8);
        end else begin
          stage_chunk(other_tag(), $urandom_range(0, 20));
        end
      end
      send_staged(1'b1);
      wait_idle();
    end

    // Close the file one way; whatever follows is swallowed
    calm   = 1'b0;
    ending = $urandom_range(0, 5);
    if (ending != 5) write_length(32'hFFFF_FFFF);
    case (ending)
      0: begin
        ending_name = "chunk overrun";
        pick = $urandom_range(0, 2);
        stage_tag(pick == 0 ? TAG_FMT : (pick == 1 ? TAG_DATA : other_tag()));
        stage_le(32'hFFFF_FFFF - $urandom_range(0, 15), 4);
      end
      1: begin
        ending_name = "fmt size";
        do len = $urandom_range(0, 40); while (len == 16);
        stage_tag(TAG_FMT);
        stage_le(len, 4);
      end
      2: begin
        ending_name = "not PCM";
        do bad = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        while (bad == 16'd1);
        stage_fmt(bad, 16'd2, pick_rate(), 16'd8);
      end
      3: begin
        ending_name = "bit depth";
        do bad = 16'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 32)
                                                 : $urandom_range(0, 65535));
        while (bad == 16'd8 || bad == 16'd16);
        stage_fmt(16'd1, 16'($urandom_range(1, 2)), pick_rate(), bad);
      end
      4: begin
        ending_name = "channel count";
        do bad = 16'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 8)
                                                 : $urandom_range(0, 65535));
        while (bad == 16'd1 || bad == 16'd2);
        stage_fmt(16'd1, bad, pick_rate(), 16'($urandom_range(0, 65535)));
      end
      default: begin
        ending_name = "short tail";
        stage_le($urandom, $urandom_range(1, 4));
        stage_le($urandom, $urandom_range(0, 3));
        send_staged(1'b1);
        wait_idle();
        write_length(32'hFFFF_FFFF);
      end
    endcase
    stage_le($urandom, 4);
    stage_le($urandom, 2);
    send_staged(1'b0);
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("Parsed %0d bytes over %0d length writes, closing with %s.",
             bytes_taken, n_writes, ending_name);
    $display("Checked %0d results: %0d payload, %0d summary, %0d error; %0d mismatches.",
             results_seen, n_payload, n_summary, n_error, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timed out waiting for the parser");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
design/wph_pkg.sv
design/wph_core.sv
design/wph_fifo.sv
design/wav_pcm_header_parser.sv
sim/tb_top.sv
